@@ rtl/core/tcs_pkg.sv @@
// shared types, codes and constants of the text console scrollback block
package tcs_pkg;

    // default sizes of the cell store
    localparam int ROW_CAP_DEF    = 64;
    localparam int COL_CAP_DEF    = 128;
    localparam int COLOR_BITS_DEF = 16;

    // depth of the queues between the parts and on the result side
    localparam int QUEUE_DEPTH = 2;

    // item field widths
    localparam int OP_W       = 4;
    localparam int CHAR_W     = 8;
    localparam int IN_ROW_W   = 6;
    localparam int IN_COL_W   = 7;
    localparam int OUT_ROW_W  = 6;
    localparam int OUT_COL_W  = 7;
    localparam int PORT_COL_W = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int ROWS_W     = 7;
    localparam int COLS_W     = 8;
    localparam int VIS_W      = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VIS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAPER = 3'd4;

    localparam logic [ROWS_W-1:0]     ROWS_RESET  = 7'd64;
    localparam logic [COLS_W-1:0]     COLS_RESET  = 8'd80;
    localparam logic [VIS_W-1:0]      VIS_RESET   = 7'd16;
    localparam logic [PORT_COL_W-1:0] INK_RESET   = 16'hFFFF;
    localparam logic [PORT_COL_W-1:0] PAPER_RESET = 16'h0000;

    // command codes of an input item
    typedef enum logic [OP_W-1:0] {
        OP_CHAR   = 4'd0,
        OP_UP     = 4'd1,
        OP_DOWN   = 4'd2,
        OP_LEFT   = 4'd3,
        OP_RIGHT  = 4'd4,
        OP_BKSP   = 4'd5,
        OP_ENTER  = 4'd6,
        OP_RETURN = 4'd7,
        OP_INSERT = 4'd8,
        OP_READ   = 4'd9
    } t_op;

    // what the back end does with the cell store for one item
    typedef enum logic [1:0] {
        MK_NONE,
        MK_PUT,
        MK_CLEAR,
        MK_READ
    } t_mem_kind;

    // pointer part of a result item
    typedef struct packed {
        logic [OUT_ROW_W-1:0] write_row;
        logic [OUT_COL_W-1:0] write_col;
        logic [OUT_COL_W-1:0] view_col;
        logic [OUT_ROW_W-1:0] view_row;
        logic [OUT_ROW_W-1:0] back_depth;
        logic [OUT_ROW_W-1:0] back_view;
        logic [OUT_ROW_W-1:0] rows_filled;
    } t_ptrs;

    // classified item handed from front to back
    typedef struct packed {
        t_mem_kind         kind;
        logic [CHAR_W-1:0] ch;
        t_ptrs             ptrs;
    } t_cmd_info;

    // complete result item
    typedef struct packed {
        t_ptrs                 ptrs;
        logic [CHAR_W-1:0]     cell_char;
        logic [PORT_COL_W-1:0] cell_ink;
        logic [PORT_COL_W-1:0] cell_paper;
    } t_result;

endpackage

@@ rtl/core/text_console_scrollback.sv @@
// top level of the text console scrollback block
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+---------------------------------------
//  command  | in        | push / full             | i_op, i_char_code, i_read_row, i_read_col
//  result   | out       | empty / pop             | o_write_row_out .. o_cell_paper
//  config   | in        | i_cfg_we (no wait)      | i_cfg_idx, i_cfg_data
//
//  front end updates pointers in the cycle an item is accepted; up to two items wait for the
//  back end, which takes one item at a time and for enter clears every column in use, one
//  column a cycle through the character memory write port; each result passes a stage register.
//  after reset the store is swept one entry a cycle over all 2**(clog2(ROW_CAP)+clog2(COL_CAP))
//  entries (8192 by default), with full held high; config writes are taken meanwhile.
//  results wait in a two-entry queue; a stalled pop holds the back end, then the front once
//  the two-entry command queue has filled up.
module text_console_scrollback import tcs_pkg::*; #(
    parameter int ROW_CAP    = ROW_CAP_DEF,
    parameter int COL_CAP    = COL_CAP_DEF,
    parameter int COLOR_BITS = COLOR_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [OP_W-1:0]       i_op,
    input  logic [CHAR_W-1:0]     i_char_code,
    input  logic [IN_ROW_W-1:0]   i_read_row,
    input  logic [IN_COL_W-1:0]   i_read_col,
    output logic                  empty,
    input  logic                  pop,
    output logic [OUT_ROW_W-1:0]  o_write_row_out,
    output logic [OUT_COL_W-1:0]  o_write_col_out,
    output logic [OUT_COL_W-1:0]  o_view_col_out,
    output logic [OUT_ROW_W-1:0]  o_view_row_out,
    output logic [OUT_ROW_W-1:0]  o_back_depth_out,
    output logic [OUT_ROW_W-1:0]  o_back_view_out,
    output logic [OUT_ROW_W-1:0]  o_rows_filled,
    output logic [CHAR_W-1:0]     o_cell_char,
    output logic [PORT_COL_W-1:0] o_cell_ink,
    output logic [PORT_COL_W-1:0] o_cell_paper,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int RW    = $clog2(ROW_CAP);
    localparam int CW    = $clog2(COL_CAP);
    localparam int CMD_W = $bits(t_cmd_info) + RW + CW;

    logic [ROWS_W-1:0]     r_cfg_rows;
    logic [COLS_W-1:0]     r_cfg_cols;
    logic [VIS_W-1:0]      r_cfg_vis;
    logic [PORT_COL_W-1:0] r_cfg_ink;
    logic [PORT_COL_W-1:0] r_cfg_paper;

    logic          sweeping;
    logic          cmd_full;
    logic          cmd_empty;
    logic          cmd_push;
    logic          cmd_pop;
    t_cmd_info     front_info;
    logic [RW-1:0] front_row;
    logic [CW-1:0] front_col;
    t_cmd_info     back_info;
    logic [RW-1:0] back_row;
    logic [CW-1:0] back_col;
    t_result       result;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rows  <= ROWS_RESET;
            r_cfg_cols  <= COLS_RESET;
            r_cfg_vis   <= VIS_RESET;
            r_cfg_ink   <= INK_RESET;
            r_cfg_paper <= PAPER_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROWS:  r_cfg_rows  <= i_cfg_data[ROWS_W-1:0];
                CFG_COLS:  r_cfg_cols  <= i_cfg_data[COLS_W-1:0];
                CFG_VIS:   r_cfg_vis   <= i_cfg_data[VIS_W-1:0];
                CFG_INK:   r_cfg_ink   <= i_cfg_data[PORT_COL_W-1:0];
                CFG_PAPER: r_cfg_paper <= i_cfg_data[PORT_COL_W-1:0];
                default: begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    tcs_front #(
        .ROW_CAP (ROW_CAP),
        .COL_CAP (COL_CAP)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_op        (i_op),
        .i_char_code (i_char_code),
        .i_read_row  (i_read_row),
        .i_read_col  (i_read_col),
        .i_cfg_rows  (r_cfg_rows),
        .i_cfg_cols  (r_cfg_cols),
        .i_cfg_vis   (r_cfg_vis),
        .i_sweeping  (sweeping),
        .i_cmd_full  (cmd_full),
        .o_cmd_push  (cmd_push),
        .o_cmd_info  (front_info),
        .o_cmd_row   (front_row),
        .o_cmd_col   (front_col)
    );

    // queue between front and back
    tcs_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  ({front_info, front_row, front_col}),
        .i_pop   (cmd_pop),
        .o_data  ({back_info, back_row, back_col}),
        .o_full  (cmd_full),
        .o_empty (cmd_empty),
        .o_count ()
    );

    tcs_back #(
        .ROW_CAP    (ROW_CAP),
        .COL_CAP    (COL_CAP),
        .COLOR_BITS (COLOR_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!cmd_empty),
        .i_cmd_info  (back_info),
        .i_cmd_row   (back_row),
        .i_cmd_col   (back_col),
        .o_cmd_pop   (cmd_pop),
        .i_ink       (r_cfg_ink),
        .i_paper     (r_cfg_paper),
        .o_sweeping  (sweeping),
        .i_res_pop   (pop),
        .o_res_empty (empty),
        .o_result    (result)
    );

    // result fields
    assign o_write_row_out  = result.ptrs.write_row;
    assign o_write_col_out  = result.ptrs.write_col;
    assign o_view_col_out   = result.ptrs.view_col;
    assign o_view_row_out   = result.ptrs.view_row;
    assign o_back_depth_out = result.ptrs.back_depth;
    assign o_back_view_out  = result.ptrs.back_view;
    assign o_rows_filled    = result.ptrs.rows_filled;
    assign o_cell_char      = result.cell_char;
    assign o_cell_ink       = result.cell_ink;
    assign o_cell_paper     = result.cell_paper;

endmodule

@@ rtl/core/tcs_fifo.sv @@
// small register queue used between front and back and on the result side
module tcs_fifo import tcs_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_full,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [NW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

@@ rtl/core/tcs_front.sv @@
// front end: accepts items, updates the row and column pointers, classifies store access
module tcs_front import tcs_pkg::*; #(
    parameter int ROW_CAP = ROW_CAP_DEF,
    parameter int COL_CAP = COL_CAP_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    output logic                            o_full,
    input  logic [OP_W-1:0]                 i_op,
    input  logic [CHAR_W-1:0]               i_char_code,
    input  logic [IN_ROW_W-1:0]             i_read_row,
    input  logic [IN_COL_W-1:0]             i_read_col,
    input  logic [ROWS_W-1:0]               i_cfg_rows,
    input  logic [COLS_W-1:0]               i_cfg_cols,
    input  logic [VIS_W-1:0]                i_cfg_vis,
    input  logic                            i_sweeping,
    input  logic                            i_cmd_full,
    output logic                            o_cmd_push,
    output t_cmd_info                       o_cmd_info,
    output logic [$clog2(ROW_CAP)-1:0]      o_cmd_row,
    output logic [$clog2(COL_CAP)-1:0]      o_cmd_col
);

    localparam int RW = $clog2(ROW_CAP);
    localparam int CW = $clog2(COL_CAP);
    localparam int WW = RW + 8;

    // pointer registers
    logic [RW-1:0] r_old, r_wr, r_vr, r_bd, r_bv;
    logic [CW-1:0] r_wc, r_vc;
    logic [RW-1:0] n_old, n_wr, n_vr, n_bd, n_bv;
    logic [CW-1:0] n_wc, n_vc;

    // saturated copies at the start of an item
    logic [RW-1:0] s_old, s_wr, s_vr, s_bd, s_bv;
    logic [CW-1:0] s_wc, s_vc;

    logic [RW-1:0] rm1;
    logic [CW-1:0] cm1;
    logic [VIS_W-1:0] vm1;
    logic [RW-1:0] fill_pre;
    logic [RW:0]   up_bd;
    logic          accept;
    t_mem_kind     kind;
    logic [CHAR_W-1:0] cmd_ch;

    // ring size over the rows, ring distance from oldest to write row
    function automatic logic [RW-1:0] f_filled(input logic [RW-1:0] wr,
                                               input logic [RW-1:0] old,
                                               input logic [RW-1:0] lim);
        if (wr >= old) begin
            return wr - old;
        end
        return wr - old + lim + 1'b1;
    endfunction

    assign o_full     = i_sweeping || i_cmd_full;
    assign accept     = i_push && !o_full;
    assign o_cmd_push = accept;

    // effective geometry from the registers
    always_comb begin
        if (i_cfg_rows == '0) begin
            rm1 = '0;
        end else if (32'(i_cfg_rows) > ROW_CAP) begin
            rm1 = RW'(ROW_CAP - 1);
        end else begin
            rm1 = RW'(i_cfg_rows - 7'd1);
        end
        if (i_cfg_cols == '0) begin
            cm1 = '0;
        end else if (32'(i_cfg_cols) > COL_CAP) begin
            cm1 = CW'(COL_CAP - 1);
        end else begin
            cm1 = CW'(i_cfg_cols - 8'd1);
        end
        vm1 = (i_cfg_vis == '0) ? '0 : i_cfg_vis - 7'd1;
    end

    // pull pointers back into a ring that may have shrunk
    always_comb begin
        s_old = (r_old > rm1) ? rm1 : r_old;
        s_wr  = (r_wr  > rm1) ? rm1 : r_wr;
        s_vr  = (r_vr  > rm1) ? rm1 : r_vr;
        s_bd  = (r_bd  > rm1) ? rm1 : r_bd;
        s_bv  = (r_bv  > rm1) ? rm1 : r_bv;
        s_wc  = (r_wc  > cm1) ? cm1 : r_wc;
        s_vc  = (r_vc  > cm1) ? cm1 : r_vc;
        fill_pre = f_filled(s_wr, s_old, rm1);
        up_bd    = {1'b0, s_bd} + 1'b1;
    end

    // per-command pointer update and store access
    always_comb begin
        n_old  = s_old;
        n_wr   = s_wr;
        n_vr   = s_vr;
        n_bd   = s_bd;
        n_bv   = s_bv;
        n_wc   = s_wc;
        n_vc   = s_vc;
        kind   = MK_NONE;
        o_cmd_row = s_wr;
        o_cmd_col = s_wc;
        cmd_ch = i_char_code;
        unique case (t_op'(i_op))
            OP_CHAR: begin
                kind = MK_PUT;
                if (s_wc == cm1) begin
                    n_wc = '0;
                    n_wr = (s_wr < rm1) ? s_wr + 1'b1 : '0;
                    if (n_wr == s_old) begin
                        n_old = (s_old < rm1) ? s_old + 1'b1 : '0;
                    end
                end else begin
                    n_wc = s_wc + 1'b1;
                end
                n_bd = '0;
                n_bv = '0;
                n_vc = n_wc;
            end
            OP_UP: begin
                n_bd = (up_bd > {1'b0, fill_pre}) ? fill_pre : up_bd[RW-1:0];
                if (WW'(n_bd) > WW'(s_bv) + WW'(vm1)) begin
                    n_bv = s_bv + 1'b1;
                end
            end
            OP_DOWN: begin
                if (s_bv == s_bd) begin
                    n_bv = (s_bv == '0) ? '0 : s_bv - 1'b1;
                end
                n_bd = (s_bd == '0) ? '0 : s_bd - 1'b1;
            end
            OP_LEFT: begin
                if (s_vc == '0) begin
                    if (fill_pre > s_bd) begin
                        n_vc = cm1;
                        n_bd = (s_bd < rm1) ? s_bd + 1'b1 : rm1;
                        if (WW'(n_bd) > WW'(s_bv) + WW'(vm1)) begin
                            n_bv = s_bv + 1'b1;
                        end
                    end
                end else begin
                    n_vc = s_vc - 1'b1;
                end
            end
            OP_RIGHT: begin
                if (s_bd == '0) begin
                    if (s_vc < s_wc) begin
                        n_vc = s_vc + 1'b1;
                    end
                end else if (s_vc == cm1) begin
                    // wrap to the next row down in the view
                    n_vc = '0;
                    if (s_bv == s_bd) begin
                        n_bv = (s_bv == '0) ? '0 : s_bv - 1'b1;
                    end
                    n_bd = s_bd - 1'b1;
                end else begin
                    n_vc = s_vc + 1'b1;
                end
            end
            OP_BKSP: begin
                if (s_wc == '0) begin
                    if (fill_pre != '0) begin
                        n_wc = cm1;
                        n_wr = (s_wr == '0) ? rm1 : s_wr - 1'b1;
                    end
                end else begin
                    n_wc = s_wc - 1'b1;
                end
                kind      = MK_PUT;
                o_cmd_row = n_wr;
                o_cmd_col = n_wc;
                cmd_ch    = '0;
                n_bd = '0;
                n_vc = n_wc;
                n_vr = n_wr;
            end
            OP_ENTER: begin
                n_wc = '0;
                n_wr = (s_wr < rm1) ? s_wr + 1'b1 : '0;
                if (n_wr == s_old) begin
                    n_old = (s_old < rm1) ? s_old + 1'b1 : '0;
                end
                // back end clears columns up to the last one in use
                kind      = MK_CLEAR;
                o_cmd_row = n_wr;
                o_cmd_col = cm1;
                n_bd = '0;
                n_bv = '0;
                n_vc = '0;
                n_vr = n_wr;
            end
            OP_RETURN: begin
                n_wc = '0;
                n_vc = '0;
            end
            OP_READ: begin
                if (32'(i_read_row) < ROW_CAP && 32'(i_read_col) < COL_CAP) begin
                    kind      = MK_READ;
                    o_cmd_row = RW'(i_read_row);
                    o_cmd_col = CW'(i_read_col);
                end
            end
            default: begin
                // insert and unused codes change nothing
            end
        endcase
    end

    // command to the back end
    always_comb begin
        o_cmd_info.kind             = kind;
        o_cmd_info.ch               = cmd_ch;
        o_cmd_info.ptrs.write_row   = OUT_ROW_W'(n_wr);
        o_cmd_info.ptrs.write_col   = OUT_COL_W'(n_wc);
        o_cmd_info.ptrs.view_col    = OUT_COL_W'(n_vc);
        o_cmd_info.ptrs.view_row    = OUT_ROW_W'(n_vr);
        o_cmd_info.ptrs.back_depth  = OUT_ROW_W'(n_bd);
        o_cmd_info.ptrs.back_view   = OUT_ROW_W'(n_bv);
        o_cmd_info.ptrs.rows_filled = OUT_ROW_W'(f_filled(n_wr, n_old, rm1));
    end

    // pointer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_old <= '0;
            r_wr  <= '0;
            r_vr  <= '0;
            r_bd  <= '0;
            r_bv  <= '0;
            r_wc  <= '0;
            r_vc  <= '0;
        end else if (accept) begin
            r_old <= n_old;
            r_wr  <= n_wr;
            r_vr  <= n_vr;
            r_bd  <= n_bd;
            r_bv  <= n_bv;
            r_wc  <= n_wc;
            r_vc  <= n_vc;
        end
    end

endmodule

@@ rtl/core/tcs_back.sv @@
// back end: cell store, reset sweep, row clear, cell read and result queue
module tcs_back import tcs_pkg::*; #(
    parameter int ROW_CAP    = ROW_CAP_DEF,
    parameter int COL_CAP    = COL_CAP_DEF,
    parameter int COLOR_BITS = COLOR_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmd_valid,
    input  t_cmd_info                  i_cmd_info,
    input  logic [$clog2(ROW_CAP)-1:0] i_cmd_row,
    input  logic [$clog2(COL_CAP)-1:0] i_cmd_col,
    output logic                       o_cmd_pop,
    input  logic [PORT_COL_W-1:0]      i_ink,
    input  logic [PORT_COL_W-1:0]      i_paper,
    output logic                       o_sweeping,
    input  logic                       i_res_pop,
    output logic                       o_res_empty,
    output t_result                    o_result
);

    localparam int RW    = $clog2(ROW_CAP);
    localparam int CW    = $clog2(COL_CAP);
    localparam int AW    = RW + CW;
    localparam int DEPTH = 2 ** AW;
    localparam int NW    = $clog2(QUEUE_DEPTH + 1);
    localparam int RES_W = $bits(t_result);

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_RUN,
        ST_CLEAR
    } t_state;

    // cell store: characters and colors kept apart so a row clear keeps colors
    logic [CHAR_W-1:0]       r_char_mem  [DEPTH];
    logic [2*COLOR_BITS-1:0] r_color_mem [DEPTH];
    logic [CHAR_W-1:0]       r_char_q;
    logic [2*COLOR_BITS-1:0] r_color_q;

    t_state          r_state;
    logic [AW-1:0]   r_sweep_addr;
    logic [RW-1:0]   r_clr_row;
    logic [CW-1:0]   r_clr_col;
    logic [CW-1:0]   r_clr_last;
    t_cmd_info       r_hold;
    logic            r_stage_v;
    t_cmd_info       r_stage;

    logic                    char_we;
    logic [AW-1:0]           char_waddr;
    logic [CHAR_W-1:0]       char_wdata;
    logic                    color_we;
    logic [AW-1:0]           color_waddr;
    logic [2*COLOR_BITS-1:0] color_wdata;
    logic [AW-1:0]           rd_addr;
    logic [NW-1:0]           res_count;
    logic                    res_full;
    logic                    credit;
    t_result                 res_data;

    assign o_sweeping = (r_state == ST_SWEEP);
    assign rd_addr    = {i_cmd_row, i_cmd_col};

    // a new item starts only if its result has a queue slot reserved
    assign credit    = (32'(res_count) + 32'(r_stage_v)) < QUEUE_DEPTH;
    assign o_cmd_pop = (r_state == ST_RUN) && i_cmd_valid && credit;

    // store write port selection
    always_comb begin
        char_we     = 1'b0;
        char_waddr  = {i_cmd_row, i_cmd_col};
        char_wdata  = i_cmd_info.ch;
        color_we    = 1'b0;
        color_waddr = {i_cmd_row, i_cmd_col};
        color_wdata = {COLOR_BITS'(i_ink), COLOR_BITS'(i_paper)};
        unique case (r_state)
            ST_SWEEP: begin
                char_we     = 1'b1;
                char_waddr  = r_sweep_addr;
                char_wdata  = '0;
                color_we    = 1'b1;
                color_waddr = r_sweep_addr;
                color_wdata = {COLOR_BITS'(INK_RESET), COLOR_BITS'(PAPER_RESET)};
            end
            ST_RUN: begin
                if (o_cmd_pop && i_cmd_info.kind == MK_PUT) begin
                    char_we  = 1'b1;
                    color_we = 1'b1;
                end else if (o_cmd_pop && i_cmd_info.kind == MK_CLEAR) begin
                    char_we    = 1'b1;
                    char_waddr = {i_cmd_row, {CW{1'b0}}};
                    char_wdata = '0;
                end
            end
            ST_CLEAR: begin
                char_we    = 1'b1;
                char_waddr = {r_clr_row, r_clr_col};
                char_wdata = '0;
            end
            default: begin
                char_we = 1'b0;
            end
        endcase
    end

    // character memory
    always_ff @(posedge i_clk) begin
        if (char_we) begin
            r_char_mem[char_waddr] <= char_wdata;
        end
        r_char_q <= r_char_mem[rd_addr];
    end

    // color memory
    always_ff @(posedge i_clk) begin
        if (color_we) begin
            r_color_mem[color_waddr] <= color_wdata;
        end
        r_color_q <= r_color_mem[rd_addr];
    end

    // sequencer: reset sweep, command issue, row clear, result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SWEEP;
            r_sweep_addr <= '0;
            r_stage_v    <= 1'b0;
        end else begin
            r_stage_v <= 1'b0;
            unique case (r_state)
                ST_SWEEP: begin
                    r_sweep_addr <= r_sweep_addr + 1'b1;
                    if (r_sweep_addr == '1) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (o_cmd_pop) begin
                        if (i_cmd_info.kind == MK_CLEAR && i_cmd_col != '0) begin
                            r_state    <= ST_CLEAR;
                            r_clr_row  <= i_cmd_row;
                            r_clr_col  <= CW'(1);
                            r_clr_last <= i_cmd_col;
                            r_hold     <= i_cmd_info;
                        end else begin
                            r_stage_v <= 1'b1;
                            r_stage   <= i_cmd_info;
                        end
                    end
                end
                ST_CLEAR: begin
                    if (r_clr_col == r_clr_last) begin
                        r_state   <= ST_RUN;
                        r_stage_v <= 1'b1;
                        r_stage   <= r_hold;
                    end else begin
                        r_clr_col <= r_clr_col + 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_RUN;
                end
            endcase
        end
    end

    // result assembly, cell fields only for a read
    always_comb begin
        res_data.ptrs = r_stage.ptrs;
        if (r_stage.kind == MK_READ) begin
            res_data.cell_char  = r_char_q;
            res_data.cell_ink   = PORT_COL_W'(r_color_q[2*COLOR_BITS-1:COLOR_BITS]);
            res_data.cell_paper = PORT_COL_W'(r_color_q[COLOR_BITS-1:0]);
        end else begin
            res_data.cell_char  = '0;
            res_data.cell_ink   = '0;
            res_data.cell_paper = '0;
        end
    end

    tcs_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_stage_v),
        .i_data  (res_data),
        .i_pop   (i_res_pop),
        .o_data  (o_result),
        .o_full  (res_full),
        .o_empty (o_res_empty),
        .o_count (res_count)
    );

    // reserved slot must exist when a result lands
    a_stage_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stage_v |-> !res_full)
        else $error("result stage pushed into a full queue");

    // items other than a row clear raise the result stage on the next cycle
    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_pop && i_cmd_info.kind != MK_CLEAR) |=> r_stage_v)
        else $error("popped item produced no result");

    // row clear column never passes the last column in use
    a_clear_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> (r_clr_col <= r_clr_last))
        else $error("row clear ran past its last column");

    // sweep ends after the last address
    a_sweep_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP && r_sweep_addr == '1) |=> (r_state == ST_RUN))
        else $error("store sweep did not finish");

endmodule
